// ===== hw/rtl/psob_pkg.sv =====
// Package for the price sorted order book: operation kinds, status codes,
// sequencer states and the packed entry type. No dependencies.
`default_nettype none
package psob_pkg;
	localparam int PRICE_W  = 20;
	localparam int QTY_W    = 24;
	localparam int CLIENT_W = 16;
	localparam int SEQ_W    = 32;
	localparam int ENTRY_W  = PRICE_W + QTY_W + CLIENT_W + SEQ_W;

	typedef enum logic [1:0] {
		KIND_ADD_BID = 2'd0,
		KIND_ADD_ASK = 2'd1,
		KIND_REM_BID = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NOSEQ = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [QTY_W-1:0]    qty;
		logic [CLIENT_W-1:0] client;
		logic [SEQ_W-1:0]    seq;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_SHIFT,
		S_REMOVE,
		S_BEST,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/psob_ram.sv =====
// Generic single port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module psob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write on the clock edge; a read of the entry being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/price_sorted_order_book_core.sv =====
// Price sorted order book, top level. Uses psob_pkg and psob_ram.
// Each side is one RAM of packed entries, walked by a sequencer.
//
// Usage: one operation word enters on the input channel (valid/ready) and
// exactly one result word leaves on the output channel (valid/ready).
// Operations run one at a time. An add scans the side from the best rank
// to find its slot, then shifts the tail down one entry at a time from the
// back. A remove makes one compacting pass over the bid RAM. Each side has
// a single RAM port: one entry is read or written per cycle. After every
// operation rank 0 is read back to give the best prices. Reset empties
// both sides and clears the sequence counter; the RAM contents are not
// cleared, since data read at or beyond the fill count is never used.
// When the receiver stalls, the result holds in the output register and
// no new operation is taken until it is delivered; the next word can be
// accepted in the cycle after delivery.
`default_nettype none
module price_sorted_order_book_core #(
	parameter int SIDE_DEPTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         kind,
	input  wire logic [psob_pkg::CLIENT_W-1:0]      client,
	input  wire logic [psob_pkg::QTY_W-1:0]         qty,
	input  wire logic [psob_pkg::PRICE_W-1:0]       limit_price,
	input  wire logic [psob_pkg::SEQ_W-1:0]         target_seq,
	input  wire logic                               read_side,
	input  wire logic [3:0]                         read_rank,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [1:0]                              status,
	output logic [psob_pkg::SEQ_W-1:0]              seq_out,
	output logic [psob_pkg::CLIENT_W-1:0]           client_out,
	output logic [psob_pkg::QTY_W-1:0]              qty_out,
	output logic [psob_pkg::PRICE_W-1:0]            price_out,
	output logic [psob_pkg::PRICE_W-1:0]            best_bid,
	output logic [psob_pkg::PRICE_W-1:0]            best_ask,
	output logic [4:0]                              bid_entries,
	output logic [4:0]                              ask_entries
);
	import psob_pkg::*;

	localparam int AW = $clog2(SIDE_DEPTH);
	localparam int FW = $clog2(SIDE_DEPTH + 1);

	// Control registers.
	state_t          state_q, state_d;
	logic [FW-1:0]   bid_fill_q, ask_fill_q;
	logic [SEQ_W-1:0] next_seq_q;
	logic            side_q;          // 0 bids, 1 asks
	logic [1:0]      kind_q;
	logic [FW-1:0]   idx_q;           // read pointer
	logic [FW-1:0]   wr_q;            // write pointer during shift and remove
	logic            pend_q;          // a read was issued last cycle
	logic [FW-1:0]   pend_idx_q;
	logic            found_q;
	logic            rank_ok_q;
	logic            out_valid_q;

	// Operation payload.
	entry_t          new_q;
	logic [SEQ_W-1:0] target_q;
	logic [3:0]      rank_q;

	// Result register.
	logic [1:0]          status_q;
	logic [SEQ_W-1:0]    seq_out_q;
	logic [CLIENT_W-1:0] client_out_q;
	logic [QTY_W-1:0]    qty_out_q;
	logic [PRICE_W-1:0]  price_out_q, best_bid_q, best_ask_q;

	// RAM ports.
	logic         bid_we, ask_we;
	logic [AW-1:0] bid_addr, ask_addr;
	entry_t       bid_wdata, ask_wdata, bid_rdata, ask_rdata;

	psob_ram #(.WIDTH(ENTRY_W), .DEPTH(SIDE_DEPTH)) u_bid_ram (
		.clk(clk), .we(bid_we), .addr(bid_addr), .wdata(bid_wdata), .rdata(bid_rdata)
	);
	psob_ram #(.WIDTH(ENTRY_W), .DEPTH(SIDE_DEPTH)) u_ask_ram (
		.clk(clk), .we(ask_we), .addr(ask_addr), .wdata(ask_wdata), .rdata(ask_rdata)
	);

	// Signals computed from the active side.
	entry_t        rdata;
	logic [FW-1:0] fill_cur;
	logic          ahead;
	logic          in_acc;
	logic          is_add;
	logic          add_full;

	assign rdata    = side_q ? ask_rdata : bid_rdata;
	assign fill_cur = side_q ? ask_fill_q : bid_fill_q;
	assign ahead    = side_q ? (rdata.price <= new_q.price) : (rdata.price >= new_q.price);
	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;

	// Decode of the incoming word: an add, and whether its side is full.
	assign is_add   = (kind_t'(kind) == KIND_ADD_BID) || (kind_t'(kind) == KIND_ADD_ASK);
	assign add_full = is_add && ((kind[0] ? ask_fill_q : bid_fill_q) >= FW'(SIDE_DEPTH));

	// Combinational RAM control and next state.
	logic          we;
	logic [AW-1:0] addr;
	entry_t        wdata;
	logic          issue;      // a read is issued this cycle
	logic [FW-1:0] issue_idx;

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		addr      = '0;
		wdata     = new_q;
		issue     = 1'b0;
		issue_idx = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (is_add) begin
						state_d = add_full ? S_BEST : S_SCAN;
					end else if (kind_t'(kind) == KIND_REM_BID) begin
						state_d = S_REMOVE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				// Read the requested rank, then the best entries.
				addr    = AW'(rank_q);
				issue   = 1'b1;
				state_d = S_BEST;
			end
			S_SCAN: begin
				// Find the first rank that the new order does not stay behind.
				if (pend_q && !ahead) begin
					state_d = S_SHIFT;
				end else if (idx_q < fill_cur) begin
					addr  = idx_q[AW-1:0];
					issue = 1'b1;
				end else if (!pend_q) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				// idx_q is the slot; wr_q walks from the fill count down.
				if (pend_q) begin
					we    = 1'b1;
					addr  = pend_idx_q[AW-1:0] + 1'b1;
					wdata = rdata;
				end else if (wr_q > idx_q) begin
					addr      = AW'(wr_q - 1'b1);
					issue     = 1'b1;
					issue_idx = wr_q - 1'b1;
				end else begin
					we      = 1'b1;
					addr    = idx_q[AW-1:0];
					issue   = 1'b1;
					state_d = S_BEST;
				end
			end
			S_REMOVE: begin
				// Compacting pass over the bid side.
				if (pend_q && rdata.seq != target_q) begin
					we    = 1'b1;
					addr  = wr_q[AW-1:0];
					wdata = rdata;
				end else if (idx_q < fill_cur) begin
					addr  = idx_q[AW-1:0];
					issue = 1'b1;
				end else if (!pend_q) begin
					issue   = 1'b1;
					state_d = S_BEST;
				end
			end
			S_BEST: begin
				addr  = '0;
				issue = 1'b1;
				if (pend_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		bid_we    = 1'b0;
		ask_we    = 1'b0;
		bid_addr  = addr;
		ask_addr  = addr;
		bid_wdata = wdata;
		ask_wdata = wdata;
		if (state_q == S_BEST) begin
			bid_addr = '0;
			ask_addr = '0;
		end else if (side_q) begin
			ask_we = we;
		end else begin
			bid_we = we;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_fill_q  <= '0;
			ask_fill_q  <= '0;
			next_seq_q  <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			idx_q       <= '0;
			wr_q        <= '0;
			side_q      <= 1'b0;
			kind_q      <= '0;
			found_q     <= 1'b0;
			rank_ok_q   <= 1'b0;
			pend_idx_q  <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			pend_q     <= issue;
			pend_idx_q <= issue_idx;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						kind_q       <= kind;
						idx_q        <= '0;
						wr_q         <= '0;
						found_q      <= 1'b0;
						client_out_q <= '0;
						qty_out_q    <= '0;
						price_out_q  <= '0;
						status_q     <= add_full ? ST_FULL : ST_OK;
						seq_out_q    <= (is_add && !add_full) ? next_seq_q : '0;
						if (is_add) begin
							side_q <= kind[0];
						end else if (kind_t'(kind) == KIND_REM_BID) begin
							side_q <= 1'b0;
						end else begin
							side_q <= read_side;
						end
					end
				end
				S_READ: begin
					rank_ok_q <= int'(rank_q) < int'(fill_cur);
				end
				S_SCAN: begin
					if (pend_q && !ahead) begin
						idx_q <= pend_idx_q;
						wr_q  <= fill_cur;
					end else if (idx_q < fill_cur) begin
						idx_q <= idx_q + 1'b1;
					end else if (!pend_q) begin
						wr_q <= fill_cur;
					end
				end
				S_SHIFT: begin
					if (!pend_q && wr_q > idx_q) begin
						wr_q <= wr_q - 1'b1;
					end else if (!pend_q) begin
						next_seq_q <= next_seq_q + 1'b1;
						if (side_q) ask_fill_q <= ask_fill_q + 1'b1;
						else        bid_fill_q <= bid_fill_q + 1'b1;
					end
				end
				S_REMOVE: begin
					if (pend_q && rdata.seq != target_q) begin
						wr_q <= wr_q + 1'b1;
					end else if (pend_q) begin
						found_q <= 1'b1;
					end
					if (!(pend_q && rdata.seq != target_q) && idx_q < fill_cur) begin
						idx_q <= idx_q + 1'b1;
					end else if (!pend_q && idx_q >= fill_cur) begin
						bid_fill_q <= wr_q;
						if (!found_q) status_q <= ST_NOSEQ;
					end
				end
				S_BEST: begin
					if (pend_q && kind_q == KIND_READ) begin
						if (rank_ok_q) begin
							seq_out_q    <= rdata.seq;
							client_out_q <= rdata.client;
							qty_out_q    <= rdata.qty;
							price_out_q  <= rdata.price;
						end else begin
							status_q <= ST_EMPTY;
						end
					end
				end
				S_DONE: begin
					best_bid_q  <= (bid_fill_q != '0) ? bid_rdata.price : '0;
					best_ask_q  <= (ask_fill_q != '0) ? ask_rdata.price : '0;
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Operation payload capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_q.price  <= limit_price;
			new_q.qty    <= qty;
			new_q.client <= client;
			new_q.seq    <= next_seq_q;
			target_q     <= target_seq;
			rank_q       <= read_rank;
		end
	end

	// Output ports.
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign seq_out     = seq_out_q;
	assign client_out  = client_out_q;
	assign qty_out     = qty_out_q;
	assign price_out   = price_out_q;
	assign best_bid    = best_bid_q;
	assign best_ask    = best_ask_q;
	assign bid_entries = 5'(bid_fill_q);
	assign ask_entries = 5'(ask_fill_q);
endmodule
`default_nettype wire
